FILE: src/wat_pkg.sv
// wat_pkg: types, codes and sizes shared by the weekly alarm table.
// Used by wat_cell, wat_head and weekly_alarm_table.
package wat_pkg;

  localparam int MAX_ENTRIES = 8;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam logic [4:0] HOUR_LIMIT   = 5'd23;
  localparam logic [5:0] MINUTE_LIMIT = 6'd59;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [1:0] FUNC_CHECK  = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_INVALID   = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [7:0] id;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [6:0] weekdays;
    logic       active;
  } entry_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] entry_id;
    logic [4:0] entry_hour;
    logic [5:0] entry_minute;
    logic [6:0] entry_weekdays;
    logic       entry_active;
    logic [2:0] now_weekday;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] assigned_id;
    logic       due;
    logic [3:0] entry_count;
  } res_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] pos;
    logic [7:0]       max_id;
    logic             hit;
  } scan_t;

endpackage

FILE: src/wat_cell.sv
// wat_cell: one table slot of the ring; loads a new entry or takes its neighbor's.
// Depends on wat_pkg.
module wat_cell (
  input  logic            clk_i,
  input  logic            load_i,
  input  logic            shift_i,
  input  wat_pkg::entry_t load_data_i,
  input  wat_pkg::entry_t nbr_i,
  output wat_pkg::entry_t entry_o
);
  import wat_pkg::*;

  entry_t entry_q, entry_d;

  always_comb begin
    priority if (load_i) begin
      entry_d = load_data_i;
    end else if (shift_i) begin
      entry_d = nbr_i;
    end else begin
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: src/wat_head.sv
// wat_head: scan unit at the head of the ring; collects id match, largest id and alarm hit.
// Depends on wat_pkg.
module wat_head (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    init_i,
  input  logic                    step_i,
  input  logic [wat_pkg::IDX_W-1:0] idx_i,
  input  wat_pkg::entry_t         entry_i,
  input  wat_pkg::cmd_t           cmd_i,
  output wat_pkg::scan_t          scan_o
);
  import wat_pkg::*;

  scan_t      scan_q, scan_d;
  logic       id_eq;
  logic       day_hit;
  logic       hit_now;
  logic [7:0] day_vec;

  always_comb begin
    day_vec = {1'b0, entry_i.weekdays};
    day_hit = day_vec[cmd_i.now_weekday];
    id_eq   = (entry_i.id == cmd_i.entry_id);
    hit_now = entry_i.active && day_hit && (entry_i.hour == cmd_i.now_hour) &&
              (entry_i.minute == cmd_i.now_minute);
    scan_d = scan_q;
    if (init_i) begin
      scan_d = '0;
    end else if (step_i) begin
      if (id_eq && !scan_q.found) begin
        scan_d.found = 1'b1;
        scan_d.pos   = idx_i;
      end
      if (entry_i.id > scan_q.max_id) begin
        scan_d.max_id = entry_i.id;
      end
      scan_d.hit = scan_q.hit | hit_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  assign scan_o = scan_q;

endmodule

FILE: src/weekly_alarm_table.sv
// weekly_alarm_table: top level; ring of wat_cell slots, wat_head scan unit, command sequencer.
// Depends on wat_pkg, wat_cell and wat_head.
//
//   channel   direction  signals                      handshake
//   command   in         start, busy, cmd_i           taken when start && !busy
//   result    out        res_valid_o, res_o           one-cycle strobe, no backpressure
//   config    in         cfg_we_i, cfg_wdata_i        written when cfg_we_i
//
// Every item passes through the scan state and then the apply state before its result
// strobe: the ring rotates once through all MAX_ENTRIES cells past the scan unit, then
// the apply state performs the add, remove or clear, or evaluates the check. busy stays
// high through both states, so an item is taken only once its predecessor is through;
// the next item can be taken in the cycle its predecessor's result is shown. Reset
// empties the table (count to zero) and sets global enable; no clearing pass is needed.
module weekly_alarm_table (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  wat_pkg::cmd_t cmd_i,
  output logic          res_valid_o,
  output wat_pkg::res_t res_o,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i
);
  import wat_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] k_q, k_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             gen_q;
  cmd_t             cmd_q;
  res_t             res_q, res_d;
  logic             res_valid_q;
  logic             accept;
  logic             fin;
  logic             fields_ok;
  logic             add_ok;
  logic             rm_ok;
  logic [7:0]       new_id;
  entry_t           new_entry;
  scan_t            scan;
  entry_t           cell_q [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] load;
  logic [MAX_ENTRIES-1:0] shift;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign fin    = (state_q == S_FIN);

  always_comb begin
    fields_ok = (cmd_q.entry_hour <= HOUR_LIMIT) && (cmd_q.entry_minute <= MINUTE_LIMIT) &&
                (cmd_q.entry_weekdays != 7'd0);
    add_ok = (cmd_q.func == FUNC_ADD) && (count_q < CNT_W'(MAX_ENTRIES)) && fields_ok &&
             !scan.found;
    rm_ok  = (cmd_q.func == FUNC_REMOVE) && scan.found;
    new_id = (cmd_q.entry_id == 8'd0) ? (scan.max_id + 8'd1) : cmd_q.entry_id;
    new_entry.id       = new_id;
    new_entry.hour     = cmd_q.entry_hour;
    new_entry.minute   = cmd_q.entry_minute;
    new_entry.weekdays = cmd_q.entry_weekdays;
    new_entry.active   = cmd_q.entry_active;
  end

  // ring of cells, each takes from its upper neighbor
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    assign load[i]  = fin && add_ok && (count_q == CNT_W'(i));
    assign shift[i] = (state_q == S_SCAN) || (fin && rm_ok && (IDX_W'(i) >= scan.pos));
    wat_cell u_cell (
      .clk_i       (clk_i),
      .load_i      (load[i]),
      .shift_i     (shift[i]),
      .load_data_i (new_entry),
      .nbr_i       (cell_q[(i + 1) % MAX_ENTRIES]),
      .entry_o     (cell_q[i])
    );
  end

  wat_head u_head (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .init_i  (accept),
    .step_i  ((state_q == S_SCAN) && (CNT_W'(k_q) < count_q)),
    .idx_i   (k_q),
    .entry_i (cell_q[0]),
    .cmd_i   (cmd_q),
    .scan_o  (scan)
  );

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    count_d = count_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN;
          k_d     = '0;
        end
      end
      S_SCAN: begin
        if (k_q == IDX_W'(MAX_ENTRIES - 1)) begin
          state_d = S_FIN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_FIN: begin
        state_d           = S_IDLE;
        res_d.status      = STAT_OK;
        res_d.assigned_id = 8'd0;
        res_d.due         = 1'b0;
        unique case (cmd_q.func)
          FUNC_ADD: begin
            priority if (count_q >= CNT_W'(MAX_ENTRIES)) begin
              res_d.status = STAT_FULL;
            end else if (!fields_ok || scan.found) begin
              res_d.status = STAT_INVALID;
            end else begin
              res_d.assigned_id = new_id;
              count_d           = count_q + 1'b1;
            end
          end
          FUNC_REMOVE: begin
            if (rm_ok) begin
              count_d = count_q - 1'b1;
            end else begin
              res_d.status = STAT_NOT_FOUND;
            end
          end
          FUNC_CLEAR: begin
            count_d = '0;
          end
          FUNC_CHECK: begin
            res_d.due = gen_q && scan.hit;
          end
          default: ;
        endcase
        res_d.entry_count = 4'(count_d);
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      count_q     <= '0;
      gen_q       <= 1'b1;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      count_q     <= count_d;
      res_valid_q <= fin;
      if (cfg_we_i) begin
        gen_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above table size");

  a_strobe_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |=> res_valid_o && !busy)
    else $error("result strobe missing after apply cycle");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_SCAN) && (k_q == '0))
    else $error("accepted item did not start a scan");

  a_scan_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && (k_q != IDX_W'(MAX_ENTRIES - 1)) |=>
      (state_q == S_SCAN) && (k_q == $past(k_q) + 1'b1))
    else $error("scan index did not advance");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fin |=> count_q == $past(count_q))
    else $error("entry count changed outside apply cycle");
`endif

endmodule
